### design/grid_astar_path_finder_core_assert.svh
// Assertion macros shared by the path finder modules
`ifndef GRID_ASTAR_PATH_FINDER_CORE_ASSERT_SVH
`define GRID_ASTAR_PATH_FINDER_CORE_ASSERT_SVH
// implication checked every cycle outside reset
`define GAP_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define GAP_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

### design/gap_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gap_pkg
// Shared constants and controller/datapath types for the grid path finder.
// ----------------------------------------------------------------------------
package gap_pkg;
  localparam int MAP_SIDE = 8;
  localparam int CELLS = 64;
  localparam logic [6:0] G_INF = 7'd127;
  localparam logic [6:0] G_MAX = 7'd126;
  localparam logic [7:0] F_INF = 8'd255;
  localparam logic [7:0] F_MAX = 8'd254;

  localparam logic [1:0] ST_PATH = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_NOPATH = 2'd2;

  localparam logic OP_LOAD = 1'b0;

  // commands from controller to datapath
  typedef struct packed {
    logic map_clr;    // clear map entry at clr_idx (after reset)
    logic init;       // latch query start and goal
    logic clr_step;   // clear cost/closed entry at clr_idx
    logic seed;       // write start into open list
    logic scan_start; // begin min search
    logic scan_step;  // read next open entry
    logic pick;       // latch best, start removal
    logic shift_step; // move one open entry down
    logic close_cur;  // mark current closed, read its g
    logic nb_start;   // set up neighbour d
    logic nb_eval;    // evaluate neighbour (costs registered)
    logic nb_ins;     // write neighbour updates
    logic walk_start; // begin parent walk at goal
    logic walk_step;  // advance walk
    logic [5:0] clr_idx;
  } gap_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic shift_done;
    logic open_empty;
    logic cur_is_goal;
    logic walk_last;  // next walk cell ends the list
  } gap_sts_t;

  function automatic logic [7:0] heur(input logic [2:0] x, input logic [2:0] y,
                                      input logic [2:0] gx, input logic [2:0] gy);
    logic [2:0] dx;
    logic [2:0] dy;
    logic [6:0] s;
    begin
      dx = (x > gx) ? x - gx : gx - x;
      dy = (y > gy) ? y - gy : gy - y;
      s = 7'(dx) * 7'(dx) + 7'(dy) * 7'(dy);
      heur = {1'b0, s};
    end
  endfunction
endpackage
`default_nettype wire

### design/grid_astar_path_finder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grid_astar_path_finder_core
// A* search on an 8x8 four-neighbour grid with a loadable blocked map.
// ----------------------------------------------------------------------------
// Usage: s_axis words carry either a map load (op=0) or a path query (op=1).
// A load gives no output. A query gives one or more
// m_axis words: path cells from goal back toward start, tlast on the final
// one, or a single word with empty-path or no-path status.
// Query setup clears the cost tables. Each expansion
// scans the open list through a two-stage read pipeline, shifts it, and
// checks four neighbours, each with an open-list membership scan.
// Path words then stream out one a cycle while the receiver is ready.
// One query at a time: s_axis_tready is low from query accept until the
// last word has been taken. Reset clears the map to all-free with
// s_axis_tready low, then idles the controller.
// A stalled receiver holds the output word and pauses the walk.
// ----------------------------------------------------------------------------
module grid_astar_path_finder_core (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic s_axis_tready,
  // tdata: cell_x[2:0], cell_y[5:3], blocked[6], goal_x[9:7], goal_y[12:10], zero[15:13]
  input  wire logic [15:0] s_axis_tdata,
  // tuser: op
  input  wire logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  wire logic m_axis_tready,
  // tdata: status[1:0], path_x[4:2], path_y[7:5]
  output logic [7:0] m_axis_tdata,
  output logic m_axis_tlast
);
  import gap_pkg::*;

  gap_cmd_t cmd;
  gap_sts_t sts;
  logic in_fire, load_we;
  logic [2:0] walk_x, walk_y;
  logic [1:0] o_status;
  logic [2:0] o_x, o_y;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  gap_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_op(s_axis_tuser),
    .in_x(s_axis_tdata[2:0]), .in_y(s_axis_tdata[5:3]),
    .in_gx(s_axis_tdata[9:7]), .in_gy(s_axis_tdata[12:10]),
    .in_rdy(s_axis_tready), .load_we(load_we), .cmd(cmd), .sts(sts),
    .walk_x(walk_x), .walk_y(walk_y), .out_vld(m_axis_tvalid),
    .out_rdy(m_axis_tready), .out_status(o_status), .out_x(o_x), .out_y(o_y),
    .out_last(m_axis_tlast)
  );

  gap_datapath u_dp (
    .clk(clk), .rst(rst), .load_we(load_we),
    .in_x(s_axis_tdata[2:0]), .in_y(s_axis_tdata[5:3]), .in_blk(s_axis_tdata[6]),
    .in_gx(s_axis_tdata[9:7]), .in_gy(s_axis_tdata[12:10]),
    .cmd(cmd), .sts(sts), .walk_x(walk_x), .walk_y(walk_y)
  );

  assign m_axis_tdata = {o_y, o_x, o_status};
endmodule
`default_nettype wire

### design/gap_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gap_datapath
// Map, cost, parent and open-list storage with the search arithmetic.
// ----------------------------------------------------------------------------
module gap_datapath (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic load_we,
  input  wire logic [2:0] in_x,
  input  wire logic [2:0] in_y,
  input  wire logic in_blk,
  input  wire logic [2:0] in_gx,
  input  wire logic [2:0] in_gy,
  input  wire gap_pkg::gap_cmd_t cmd,
  output gap_pkg::gap_sts_t sts,
  output logic [2:0] walk_x,
  output logic [2:0] walk_y
);
  import gap_pkg::*;

  logic blocked_map [CELLS];
  logic [6:0] g_cost [CELLS];
  logic [7:0] f_cost [CELLS];
  logic [5:0] parent_cell [CELLS];
  logic [5:0] open_order [CELLS];
  logic closed_mark [CELLS];

  logic [6:0] open_count;
  logic [5:0] start, goal;
  logic [2:0] gx, gy;
  logic [6:0] scan_i;
  logic [7:0] best;
  logic [5:0] pos;
  logic [5:0] best_c;
  logic [5:0] cur;
  logic [6:0] cur_g;
  logic [6:0] sh_i;
  logic [5:0] sh_q;
  logic [5:0] sh_w;
  logic shv;
  logic [1:0] dir;
  logic [5:0] nb;
  logic nb_ex;
  logic nb_blk;
  logic [6:0] tg;
  logic [7:0] tf;
  logic nb_closed;
  logic [7:0] nb_f;
  logic nb_in_open;
  logic nb_upd;
  logic [5:0] walk_c;
  logic [5:0] walk_p;
  logic [6:0] walk_n;
  logic [5:0] s_c1, s_i1, s_c2, s_i2;
  logic sv1, sv2;
  logic [7:0] s_f2;
  logic [2:0] cx, cy;

  // neighbour coordinate for current direction
  logic [2:0] nx, ny;
  logic nexists;
  always_comb begin
    nx = cx;
    ny = cy;
    nexists = 1'b1;
    unique case (dir)
      2'd0: begin
        if (cx == 3'd0) nexists = 1'b0; else nx = cx - 3'd1;
      end
      2'd1: begin
        if (32'(cx) + 1 >= MAP_SIDE) nexists = 1'b0; else nx = cx + 3'd1;
      end
      2'd2: begin
        if (cy == 3'd0) nexists = 1'b0; else ny = cy - 3'd1;
      end
      default: begin
        if (32'(cy) + 1 >= MAP_SIDE) nexists = 1'b0; else ny = cy + 3'd1;
      end
    endcase
  end

  assign cx = cur[2:0];
  assign cy = cur[5:3];

  logic [7:0] tf_sum;
  assign tf_sum = {1'b0, tg} + heur(nb[2:0], nb[5:3], gx, gy);

  assign nb_upd = nb_ex && !nb_blk && !(nb_closed && tf >= nb_f) &&
                  (!nb_in_open || tf < nb_f);

  always_ff @(posedge clk) begin
    if (cmd.map_clr) blocked_map[cmd.clr_idx] <= 1'b0;
    else if (load_we) blocked_map[{in_y, in_x}] <= in_blk;
    if (cmd.init) begin
      start <= {in_y, in_x};
      goal <= {in_gy, in_gx};
      gx <= in_gx;
      gy <= in_gy;
    end
    if (cmd.clr_step) begin
      g_cost[cmd.clr_idx] <= G_INF;
      f_cost[cmd.clr_idx] <= F_INF;
      closed_mark[cmd.clr_idx] <= 1'b0;
    end
    if (cmd.seed) begin
      open_order[0] <= start;
      g_cost[start] <= 7'd0;
      f_cost[start] <= (heur(start[2:0], start[5:3], gx, gy) > F_MAX) ? F_MAX :
                       heur(start[2:0], start[5:3], gx, gy);
    end
    if (cmd.scan_start) begin
      scan_i <= 7'd0;
      best <= F_INF;
      pos <= 6'd0;
      sv1 <= 1'b0;
      sv2 <= 1'b0;
      nb_in_open <= 1'b0;
    end
    // shared read stage: one open entry a cycle, for min search and membership
    if (cmd.scan_step || cmd.nb_eval) begin
      if (scan_i < open_count) begin
        s_c1 <= open_order[scan_i[5:0]];
        s_i1 <= scan_i[5:0];
        sv1 <= 1'b1;
        scan_i <= scan_i + 7'd1;
      end else begin
        sv1 <= 1'b0;
      end
    end
    if (cmd.scan_step) begin
      sv2 <= sv1;
      s_c2 <= s_c1;
      s_i2 <= s_i1;
      s_f2 <= f_cost[s_c1];
      // first entry always wins, later ones only on a strictly lower f
      if (sv2 && (s_f2 < best || s_i2 == 6'd0)) begin
        best <= s_f2;
        pos <= s_i2;
        best_c <= s_c2;
      end
    end
    if (cmd.pick) begin
      cur <= best_c;
      sh_i <= {1'b0, pos};
      shv <= 1'b0;
    end
    if (cmd.shift_step) begin
      if (sh_i < open_count) begin
        sh_q <= open_order[sh_i[5:0] + 6'd1];
        sh_w <= sh_i[5:0];
        shv <= 1'b1;
        sh_i <= sh_i + 7'd1;
      end else begin
        shv <= 1'b0;
      end
      if (shv) open_order[sh_w] <= sh_q;
    end
    if (cmd.close_cur) begin
      closed_mark[cur] <= 1'b1;
      cur_g <= g_cost[cur];
      dir <= 2'd0;
    end
    if (cmd.nb_start) begin
      nb <= {ny, nx};
      nb_ex <= nexists;
      nb_blk <= blocked_map[{ny, nx}];
      tg <= (cur_g >= G_MAX) ? G_MAX : cur_g + 7'd1;
      nb_closed <= closed_mark[{ny, nx}];
      nb_f <= f_cost[{ny, nx}];
      nb_in_open <= 1'b0;
      scan_i <= 7'd0;
      sv1 <= 1'b0;
    end
    if (cmd.nb_eval) begin
      tf <= (tf_sum > F_MAX) ? F_MAX : tf_sum;
      if (sv1 && s_c1 == nb) nb_in_open <= 1'b1;
    end
    if (cmd.nb_ins) begin
      if (nb_upd) begin
        parent_cell[nb] <= cur;
        g_cost[nb] <= tg;
        f_cost[nb] <= tf;
        if (!nb_in_open && open_count < 7'(CELLS)) open_order[open_count[5:0]] <= nb;
      end
      dir <= dir + 2'd1;
    end
    if (cmd.walk_start) begin
      walk_c <= goal;
      walk_p <= parent_cell[goal];
      walk_n <= 7'd0;
    end
    if (cmd.walk_step) begin
      walk_c <= walk_p;
      walk_p <= parent_cell[walk_p];
      walk_n <= walk_n + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_count <= 7'd0;
    end else if (cmd.seed) begin
      open_count <= 7'd1;
    end else if (cmd.pick) begin
      open_count <= open_count - 7'd1;
    end else if (cmd.nb_ins && nb_upd && !nb_in_open && open_count < 7'(CELLS)) begin
      open_count <= open_count + 7'd1;
    end
  end

  assign sts.scan_done = (scan_i >= open_count) && !sv1 && !sv2;
  // after pick, open_count already decremented; entries up to open_count shift
  assign sts.shift_done = (sh_i >= open_count) && !shv;
  assign sts.open_empty = (open_count == 7'd0);
  assign sts.cur_is_goal = (best_c == goal);
  assign sts.walk_last = (walk_p == start) || (walk_n == 7'(CELLS - 1));
  assign walk_x = walk_c[2:0];
  assign walk_y = walk_c[5:3];

  `include "grid_astar_path_finder_core_assert.svh"
  `GAP_ASSERT_IMP(a_cnt_range, 1'b1, open_count <= 7'(CELLS))
  `GAP_ASSERT_NXT(a_seed_cnt, cmd.seed, open_count == 7'd1)
  `GAP_ASSERT_IMP(a_walk_lim, cmd.walk_step, walk_n < 7'(CELLS))
endmodule
`default_nettype wire

### design/gap_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gap_ctrl
// Sequencer for loads, query setup, A* expansion and path output.
// ----------------------------------------------------------------------------
module gap_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_fire,
  input  wire logic in_op,
  input  wire logic [2:0] in_x,
  input  wire logic [2:0] in_y,
  input  wire logic [2:0] in_gx,
  input  wire logic [2:0] in_gy,
  output logic in_rdy,
  output logic load_we,
  output gap_pkg::gap_cmd_t cmd,
  input  wire gap_pkg::gap_sts_t sts,
  input  wire logic [2:0] walk_x,
  input  wire logic [2:0] walk_y,
  output logic out_vld,
  input  wire logic out_rdy,
  output logic [1:0] out_status,
  output logic [2:0] out_x,
  output logic [2:0] out_y,
  output logic out_last
);
  import gap_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_CLR = 4'd1, S_SEED = 4'd2, S_SCAN0 = 4'd3,
                         S_SCAN = 4'd4, S_PICK = 4'd5, S_SHIFT = 4'd6, S_CLOSE = 4'd7,
                         S_NB0 = 4'd8, S_NBE = 4'd9, S_NBI = 4'd10, S_WALK0 = 4'd11,
                         S_WALK = 4'd12, S_ONE = 4'd13, S_INIT = 4'd14;

  logic [3:0] state;
  logic [5:0] clr_cnt;
  logic [1:0] nbd;

  assign in_rdy = (state == S_IDLE) && !out_vld;
  assign load_we = in_fire && (in_op == OP_LOAD);

  always_comb begin
    cmd = '0;
    cmd.clr_idx = clr_cnt;
    unique case (state)
      S_INIT: cmd.map_clr = 1'b1;
      S_IDLE: cmd.init = in_fire && (in_op != OP_LOAD);
      S_CLR: cmd.clr_step = 1'b1;
      S_SEED: cmd.seed = 1'b1;
      S_SCAN0: cmd.scan_start = !sts.open_empty;
      S_SCAN: cmd.scan_step = !sts.scan_done;
      S_PICK: begin
        cmd.pick = !sts.cur_is_goal;
        cmd.walk_start = sts.cur_is_goal;
      end
      S_SHIFT: cmd.shift_step = !sts.shift_done;
      S_CLOSE: cmd.close_cur = 1'b1;
      S_NB0: cmd.nb_start = 1'b1;
      S_NBE: cmd.nb_eval = 1'b1;
      S_NBI: cmd.nb_ins = 1'b1;
      S_WALK: cmd.walk_step = !out_vld || out_rdy;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      out_vld <= 1'b0;
      clr_cnt <= 6'd0;
      nbd <= 2'd0;
    end else begin
      if (out_vld && out_rdy) out_vld <= 1'b0;
      unique case (state)
        // map clear pass after reset
        S_INIT: begin
          clr_cnt <= clr_cnt + 6'd1;
          if (clr_cnt == 6'(CELLS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_fire && in_op != OP_LOAD) begin
            if (32'(in_x) >= MAP_SIDE || 32'(in_y) >= MAP_SIDE ||
                32'(in_gx) >= MAP_SIDE || 32'(in_gy) >= MAP_SIDE) begin
              out_status <= ST_NOPATH; state <= S_ONE;
            end else if (in_x == in_gx && in_y == in_gy) begin
              out_status <= ST_EMPTY; state <= S_ONE;
            end else begin
              clr_cnt <= 6'd0; state <= S_CLR;
            end
          end
        end
        S_ONE: begin
          out_x <= 3'd0; out_y <= 3'd0; out_last <= 1'b1; out_vld <= 1'b1;
          state <= S_IDLE;
        end
        S_CLR: begin
          clr_cnt <= clr_cnt + 6'd1;
          if (clr_cnt == 6'(CELLS - 1)) state <= S_SEED;
        end
        S_SEED: state <= S_SCAN0;
        S_SCAN0: begin
          if (sts.open_empty) begin
            out_status <= ST_NOPATH; state <= S_ONE;
          end else state <= S_SCAN;
        end
        S_SCAN: if (sts.scan_done) state <= S_PICK;
        S_PICK: state <= sts.cur_is_goal ? S_WALK : S_SHIFT;
        S_SHIFT: if (sts.shift_done) state <= S_CLOSE;
        S_CLOSE: begin nbd <= 2'd0; state <= S_NB0; end
        S_NB0: state <= S_NBE;
        S_NBE: if (sts.scan_done) state <= S_NBI;
        S_NBI: begin
          nbd <= nbd + 2'd1;
          state <= (nbd == 2'd3) ? S_SCAN0 : S_NB0;
        end
        S_WALK: begin
          if (!out_vld || out_rdy) begin
            out_status <= ST_PATH;
            out_x <= walk_x; out_y <= walk_y;
            out_last <= sts.walk_last;
            out_vld <= 1'b1;
            if (sts.walk_last) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "grid_astar_path_finder_core_assert.svh"
  `GAP_ASSERT_IMP(a_rdy_idle, in_rdy, state == S_IDLE)
  `GAP_ASSERT_NXT(a_hold, out_vld && !out_rdy, out_vld && $stable(out_x))
  `GAP_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0({cmd.pick, cmd.walk_start, cmd.scan_step}))
endmodule
`default_nettype wire
